@@ design/mck_pkg.sv @@
// Shared types, constants and the Morse table for the Morse code keyer.
`timescale 1ns / 1ps
`default_nettype none
package mck_pkg;

  localparam int NumSymbols = 36;
  localparam int QDepth     = 2;
  localparam int QAw        = $clog2(QDepth);

  // Register indexes on the configuration port.
  localparam logic [2:0] RegDot       = 3'd0;
  localparam logic [2:0] RegDash      = 3'd1;
  localparam logic [2:0] RegSymbolGap = 3'd2;
  localparam logic [2:0] RegLetterGap = 3'd3;
  localparam logic [2:0] RegWordGap   = 3'd4;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  // Symbol count per entry: A-Z, then 0-9.
  localparam logic [2:0] SymCount [NumSymbols] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // Symbol patterns, first symbol in the highest used bit, 1 is a dash.
  localparam logic [4:0] SymBits [NumSymbols] = '{
    5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4, 5'd3,
    5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12,
    5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
  };

  typedef enum logic [1:0] {
    JOB_BAD,
    JOB_SPACE,
    JOB_CHAR
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] count;
    logic [4:0] bits;
  } job_t;

  typedef struct packed {
    logic [15:0] dot_time;
    logic [15:0] dash_time;
    logic [15:0] symbol_gap_time;
    logic [15:0] letter_gap_time;
    logic [15:0] word_gap_time;
  } cfg_t;

  function automatic job_t classify(input logic [7:0] ch);
    job_t       job;
    logic [5:0] entry;
    job   = '{kind: JOB_BAD, count: 3'd0, bits: 5'd0};
    entry = 6'd0;
    if (ch == ChSpace) begin
      job.kind = JOB_SPACE;
    end else if (ch >= ChUpA && ch <= ChUpZ) begin
      entry    = 6'(ch - ChUpA);
      job.kind = JOB_CHAR;
    end else if (ch >= Ch0 && ch <= Ch9) begin
      entry    = 6'(ch - Ch0) + 6'd26;
      job.kind = JOB_CHAR;
    end
    if (job.kind == JOB_CHAR) begin
      job.count = SymCount[entry];
      job.bits  = SymBits[entry];
    end
    return job;
  endfunction

endpackage
`default_nettype wire

@@ design/mck_front.sv @@
// Front end: classifies each accepted character and queues the job for the back end.
`timescale 1ns / 1ps
`default_nettype none
module mck_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [7:0]    character_i,
  output logic               full_o,
  output logic               job_valid_o,
  output mck_pkg::job_t      job_o,
  input  wire logic          pop_i
);

  mck_pkg::job_t                 queue_q [mck_pkg::QDepth];
  logic [mck_pkg::QAw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [mck_pkg::QAw:0]         count_q;

  assign full_o      = (count_q == (mck_pkg::QAw+1)'(mck_pkg::QDepth));
  assign job_valid_o = (count_q != '0);
  assign job_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      queue_q[wr_ptr_q] <= mck_pkg::classify(character_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/mck_back.sv @@
// Back end: sequences the keying segments of one queued job, one segment a cycle.
`timescale 1ns / 1ps
`default_nettype none
module mck_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mck_pkg::cfg_t cfg_i,
  input  wire logic          job_valid_i,
  input  wire mck_pkg::job_t job_i,
  output logic               pop_o,
  output logic               seg_valid_o,
  output logic               led_on_o,
  output logic [15:0]        duration_o,
  output logic               bad_character_o,
  output logic               last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ON,
    S_GAP,
    S_END
  } state_e;

  state_e      state_q;
  logic [2:0]  idx_q;
  logic [4:0]  bits_q;
  logic        valid_q, led_q, bad_q, last_q;
  logic [15:0] dur_q;

  assign pop_o           = (state_q == S_IDLE) && job_valid_i;
  assign seg_valid_o     = valid_q;
  assign led_on_o        = led_q;
  assign duration_o      = dur_q;
  assign bad_character_o = bad_q;
  assign last_o          = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      bits_q  <= '0;
      valid_q <= 1'b0;
      led_q   <= 1'b0;
      bad_q   <= 1'b0;
      last_q  <= 1'b0;
      dur_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      led_q   <= 1'b0;
      bad_q   <= 1'b0;
      last_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            case (job_i.kind)
              mck_pkg::JOB_SPACE: begin
                valid_q <= 1'b1;
                last_q  <= 1'b1;
                dur_q   <= cfg_i.word_gap_time;
              end
              mck_pkg::JOB_CHAR: begin
                bits_q  <= job_i.bits;
                idx_q   <= job_i.count - 3'd1;
                state_q <= S_ON;
              end
              default: begin
                valid_q <= 1'b1;
                bad_q   <= 1'b1;
                last_q  <= 1'b1;
                dur_q   <= '0;
              end
            endcase
          end
        end
        S_ON: begin
          valid_q <= 1'b1;
          led_q   <= 1'b1;
          dur_q   <= bits_q[idx_q] ? cfg_i.dash_time : cfg_i.dot_time;
          state_q <= S_GAP;
        end
        S_GAP: begin
          valid_q <= 1'b1;
          dur_q   <= cfg_i.symbol_gap_time;
          if (idx_q == 3'd0) begin
            state_q <= S_END;
          end else begin
            idx_q   <= idx_q - 3'd1;
            state_q <= S_ON;
          end
        end
        S_END: begin
          valid_q <= 1'b1;
          last_q  <= 1'b1;
          dur_q   <= cfg_i.letter_gap_time;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/morse_code_keyer_top.sv @@
// Top level of the Morse code keyer: register file, front end, job queue and back end.
// An accepted character is queued, then taken by the idle back end, which registers the
// segment of a space or unknown character, or enters S_ON for a letter or digit, which for
// n symbols gives n lit segments, n symbol gaps and a letter gap; any other item one segment.
// The front end queues up to two items ahead of the back end; busy is high when full.
// Reset clears the queue and the sequencer and loads the default durations.
`timescale 1ns / 1ps
`default_nettype none
module morse_code_keyer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  character_i,
  output logic             seg_valid_o,
  output logic             led_on_o,
  output logic [15:0]      duration_o,
  output logic             bad_character_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  mck_pkg::cfg_t cfg_q;
  mck_pkg::job_t job;
  logic          full, job_valid, pop, push;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign busy    = full;
  assign push    = start && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_time        <= 16'd100;
      cfg_q.dash_time       <= 16'd300;
      cfg_q.symbol_gap_time <= 16'd100;
      cfg_q.letter_gap_time <= 16'd300;
      cfg_q.word_gap_time   <= 16'd700;
    end else if (cfg_wr) begin
      case (reg_idx)
        mck_pkg::RegDot:       cfg_q.dot_time        <= pwdata[15:0];
        mck_pkg::RegDash:      cfg_q.dash_time       <= pwdata[15:0];
        mck_pkg::RegSymbolGap: cfg_q.symbol_gap_time <= pwdata[15:0];
        mck_pkg::RegLetterGap: cfg_q.letter_gap_time <= pwdata[15:0];
        mck_pkg::RegWordGap:   cfg_q.word_gap_time   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mck_pkg::RegDot:       prdata = {16'd0, cfg_q.dot_time};
      mck_pkg::RegDash:      prdata = {16'd0, cfg_q.dash_time};
      mck_pkg::RegSymbolGap: prdata = {16'd0, cfg_q.symbol_gap_time};
      mck_pkg::RegLetterGap: prdata = {16'd0, cfg_q.letter_gap_time};
      mck_pkg::RegWordGap:   prdata = {16'd0, cfg_q.word_gap_time};
      default:               prdata = 32'd0;
    endcase
  end

  mck_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .character_i (character_i),
    .full_o      (full),
    .job_valid_o (job_valid),
    .job_o       (job),
    .pop_i       (pop)
  );

  mck_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .pop_o           (pop),
    .seg_valid_o     (seg_valid_o),
    .led_on_o        (led_on_o),
    .duration_o      (duration_o),
    .bad_character_o (bad_character_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

@@ design/mck_checker.sv @@
// Port-level checks for the Morse code keyer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mck_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        seg_valid_o,
  input wire logic        led_on_o,
  input wire logic [15:0] duration_o,
  input wire logic        bad_character_o,
  input wire logic        last_o,
  input wire logic        pready
);

  // An unknown character gives a single dark segment of zero length.
  a_bad_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_o && bad_character_o |-> last_o && !led_on_o && duration_o == 16'd0)
    else $error("bad character segment malformed");

  // Every lit segment is followed at once by a dark symbol gap.
  a_gap_after_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_o && led_on_o |=> seg_valid_o && !led_on_o && !last_o)
    else $error("lit segment not followed by a symbol gap");

  // A character never ends on a lit segment.
  a_lit_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_o && led_on_o |-> !last_o && !bad_character_o)
    else $error("lit segment flagged last or bad");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind morse_code_keyer_top mck_checker u_mck_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .seg_valid_o     (seg_valid_o),
  .led_on_o        (led_on_o),
  .duration_o      (duration_o),
  .bad_character_o (bad_character_o),
  .last_o          (last_o),
  .pready          (pready)
);
`default_nettype wire
